// File: hdl/nfs_pkg.sv
// Shared types and constants of the NEH flow-shop scheduler.
`default_nettype none
package nfs_pkg;

  // Control that travels with each job down the machine chain.
  typedef struct packed {
    logic valid;
    logic first;  // first job of a sequence: treat the previous row as zero
    logic tail;   // last job of a sequence: its result is the makespan
  } tok_t;

  localparam int MakespanW = 15;
  localparam logic [MakespanW-1:0] SpanMax = 15'h7fff;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_JOB_COUNT     = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_MACHINE_COUNT = 1'b1;

endpackage
`default_nettype wire

// File: hdl/nfs_cell.sv
// One machine cell: holds one column of the time matrix and one entry of the completion row.
`default_nettype none
module nfs_cell #(
  parameter int IDX = 0,
  parameter int NJ  = 64,
  parameter int JW  = 6,
  parameter int MW  = 5,
  parameter int TW  = 8,
  parameter int SW  = 15
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               wr_en_i,
  input  wire  [JW-1:0]     wr_job_i,
  input  wire  [MW-1:0]     wr_mach_i,
  input  wire  [TW-1:0]     wr_time_i,
  input  wire nfs_pkg::tok_t tok_i,
  input  wire  [JW-1:0]     job_i,
  input  wire  [SW-1:0]     left_i,
  output nfs_pkg::tok_t     tok_o,
  output logic [JW-1:0]     job_o,
  output logic [SW-1:0]     left_o
);

  logic [TW-1:0] col_mem [NJ];
  logic [TW-1:0] p_q;

  nfs_pkg::tok_t a_tok_q;
  logic [JW-1:0] a_job_q;
  logic [SW-1:0] a_left_q;
  logic [SW-1:0] row_q;
  nfs_pkg::tok_t o_tok_q;
  logic [JW-1:0] o_job_q;
  logic [SW-1:0] o_left_q;

  logic [SW-1:0] above;
  logic [SW-1:0] mx;
  logic [SW-1:0] c_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_mach_i == MW'(IDX))) begin
      col_mem[wr_job_i] <= wr_time_i;
    end
    p_q <= col_mem[job_i];
  end

  always_comb begin
    above = a_tok_q.first ? '0 : row_q;
    mx    = (above > a_left_q) ? above : a_left_q;
    c_d   = mx + SW'(p_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tok_q  <= '0;
      a_job_q  <= '0;
      a_left_q <= '0;
      row_q    <= '0;
      o_tok_q  <= '0;
      o_job_q  <= '0;
      o_left_q <= '0;
    end else begin
      a_tok_q  <= tok_i;
      a_job_q  <= job_i;
      a_left_q <= left_i;
      o_tok_q  <= a_tok_q;
      o_job_q  <= a_job_q;
      o_left_q <= c_d;
      if (a_tok_q.valid) begin
        row_q <= c_d;
      end
    end
  end

  assign tok_o  = o_tok_q;
  assign job_o  = o_job_q;
  assign left_o = o_left_q;

endmodule
`default_nettype wire

// File: hdl/nfs_chain.sv
// Row of machine cells; taps the completion time at the last active machine.
`default_nettype none
module nfs_chain #(
  parameter int NJ = 64,
  parameter int NM = 32,
  parameter int JW = 6,
  parameter int MW = 5,
  parameter int TW = 8,
  parameter int SW = 15
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               wr_en_i,
  input  wire  [JW-1:0]     wr_job_i,
  input  wire  [MW-1:0]     wr_mach_i,
  input  wire  [TW-1:0]     wr_time_i,
  input  wire nfs_pkg::tok_t tok_i,
  input  wire  [JW-1:0]     job_i,
  input  wire  [MW-1:0]     sel_i,
  output logic              done_o,
  output logic [SW-1:0]     span_o
);

  nfs_pkg::tok_t ot   [NM];
  logic [JW-1:0] oj   [NM];
  logic [SW-1:0] ol   [NM];

  for (genvar g = 0; g < NM; g++) begin : g_cell
    nfs_pkg::tok_t ct;
    logic [JW-1:0] cj;
    logic [SW-1:0] cl;
    if (g == 0) begin : g_head
      assign ct = tok_i;
      assign cj = job_i;
      assign cl = '0;
    end else begin : g_link
      assign ct = ot[g-1];
      assign cj = oj[g-1];
      assign cl = ol[g-1];
    end
    nfs_cell #(
      .IDX(g), .NJ(NJ), .JW(JW), .MW(MW), .TW(TW), .SW(SW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en_i),
      .wr_job_i (wr_job_i),
      .wr_mach_i(wr_mach_i),
      .wr_time_i(wr_time_i),
      .tok_i    (ct),
      .job_i    (cj),
      .left_i   (cl),
      .tok_o    (ot[g]),
      .job_o    (oj[g]),
      .left_o   (ol[g])
    );
  end

  assign done_o = ot[sel_i].valid && ot[sel_i].tail;
  assign span_o = ol[sel_i];

endmodule
`default_nettype wire

// File: hdl/neh_flow_shop_scheduler_core.sv
// Top level of the NEH permutation flow-shop scheduler.
// Matrix entries are taken one per cycle while idle. The entry marked tlast starts scheduling,
// and no entry is taken until the whole sequence has been sent. Every makespan
// evaluation streams the jobs of a sequence one per cycle into a row of machine
// cells, each of which registers a job in its a stage and then in its o stage.
// Scheduling n jobs runs the job totals, the priority sweeps, the insertion
// trials and the rebuild for each job after the first, and one last makespan
// evaluation; each result is then held until the receiver is ready.
`default_nettype none
module neh_flow_shop_scheduler_core #(
  parameter int MAX_JOBS     = 64,
  parameter int MAX_MACHINES = 32,
  parameter int TIME_BITS    = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // job_index [5:0], machine_index [10:6], proc_time [18:11]
  input  wire         s_axis_tlast,   // last_entry
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // position [5:0], job_id [11:6], makespan [26:12]
  output logic        m_axis_tlast,   // last_result
  input  wire         cfg_we_i,
  input  wire  [nfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [6:0]  cfg_data_i
);

  localparam int JW  = $clog2(MAX_JOBS);
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int MCW = $clog2(MAX_MACHINES + 1);
  localparam int TW  = TIME_BITS;
  localparam int SW  = $clog2((MAX_JOBS + MAX_MACHINES) * ((1 << TIME_BITS) - 1) + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUMS  = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_TRIAL = 4'd3;
  localparam logic [3:0] S_BUILD = 4'd4;
  localparam logic [3:0] S_FINAL = 4'd5;
  localparam logic [3:0] S_ORD   = 4'd6;
  localparam logic [3:0] S_OWT   = 4'd7;
  localparam logic [3:0] S_OHOLD = 4'd8;

  logic [3:0] state_q;
  logic [6:0] job_count_q;
  logic [5:0] machine_count_q;

  logic [CW-1:0]  n_q, iss_q, rc_q, ra_q, k_q, len_q, pos_q, bpos_q;
  logic [CW-1:0]  g_t_q, g_len_q, g1_t_q, o_cnt_q;
  logic [MCW-1:0] m_q;
  logic [MAX_JOBS-1:0] chosen_q;
  logic           s_run_q, sv_q, sfound_q, bfound_q, cur_q, g_run_q, g1_new_q;
  logic [JW-1:0]  sidx_q, sbest_idx_q, newjob_q;
  logic [SW-1:0]  sbest_q, bspan_q;
  nfs_pkg::tok_t  g1_tok_q;
  logic [nfs_pkg::MakespanW-1:0] span_q;
  logic [5:0]     m_pos_q, m_job_q;
  logic           m_valid_q, m_last_q;

  logic [JW-1:0]  seq0 [MAX_JOBS];
  logic [JW-1:0]  seq1 [MAX_JOBS];
  logic [SW-1:0]  sums [MAX_JOBS];
  logic [JW-1:0]  seq0_rd_q, seq1_rd_q;
  logic [SW-1:0]  sums_rd_q;

  // input unpacking
  logic [5:0]  in_job;
  logic [6:0]  in_mach;
  logic [15:0] in_time;
  logic        in_range, mat_we;
  logic [CW-1:0]  n_sat;
  logic [MCW-1:0] m_sat;

  assign in_job  = s_axis_tdata[5:0];
  assign in_mach = {2'b00, s_axis_tdata[10:6]};
  assign in_time = {8'h00, s_axis_tdata[18:11]};
  assign in_range = ({1'b0, in_job} < 7'(MAX_JOBS)) && (in_mach < 7'(MAX_MACHINES));
  assign s_axis_tready = (state_q == S_IDLE);
  assign mat_we = s_axis_tvalid && s_axis_tready && in_range;

  always_comb begin
    if (job_count_q == 7'd0) begin
      n_sat = CW'(1);
    end else if (job_count_q > 7'(MAX_JOBS)) begin
      n_sat = CW'(MAX_JOBS);
    end else begin
      n_sat = CW'(job_count_q);
    end
    if (machine_count_q == 6'd0) begin
      m_sat = MCW'(1);
    end else if ({1'b0, machine_count_q} > 7'(MAX_MACHINES)) begin
      m_sat = MCW'(MAX_MACHINES);
    end else begin
      m_sat = MCW'(machine_count_q);
    end
  end

  // sequence generator, stage 0: the inserted job takes slot pos, the rest shift up
  logic          g_new;
  logic [CW-1:0] g_addr_full;
  logic [JW-1:0] seq_rd_addr, seq_rd, g1_job;
  logic          out_phase;

  assign g_new       = (g_t_q == pos_q);
  assign g_addr_full = (g_t_q > pos_q) ? (g_t_q - CW'(1)) : g_t_q;
  assign out_phase   = (state_q == S_ORD) || (state_q == S_OWT) || (state_q == S_OHOLD);
  assign seq_rd_addr = out_phase ? o_cnt_q[JW-1:0] : g_addr_full[JW-1:0];
  assign seq_rd      = cur_q ? seq1_rd_q : seq0_rd_q;
  assign g1_job      = g1_new_q ? newjob_q : seq_rd;

  // chain feed
  nfs_pkg::tok_t ch_tok;
  logic [JW-1:0] ch_job;
  logic          ch_done;
  logic [SW-1:0] ch_span;
  logic [MCW-1:0] m_last_idx;

  assign m_last_idx = m_q - MCW'(1);

  always_comb begin
    if (state_q == S_SUMS) begin
      ch_tok.valid = (iss_q < n_q);
      ch_tok.first = 1'b1;
      ch_tok.tail  = 1'b1;
      ch_job       = iss_q[JW-1:0];
    end else begin
      ch_tok       = g1_tok_q;
      ch_tok.valid = g1_tok_q.valid && (state_q != S_BUILD);
      ch_job       = g1_job;
    end
  end

  nfs_chain #(
    .NJ(MAX_JOBS), .NM(MAX_MACHINES), .JW(JW), .MW(MW), .TW(TW), .SW(SW)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (mat_we),
    .wr_job_i (in_job[JW-1:0]),
    .wr_mach_i(in_mach[MW-1:0]),
    .wr_time_i(in_time[TW-1:0]),
    .tok_i    (ch_tok),
    .job_i    (ch_job),
    .sel_i    (m_last_idx[MW-1:0]),
    .done_o   (ch_done),
    .span_o   (ch_span)
  );

  // priority sweep and trial compares, sequence and total write ports
  logic          cand, pick_fin, better, wr_a, wr_b, we0, we1, sum_we;
  logic [JW-1:0] fin_idx, wa, wd;
  logic [nfs_pkg::MakespanW-1:0] span_sat;

  assign cand     = !chosen_q[sidx_q] && (!sfound_q || (sums_rd_q > sbest_q));
  assign pick_fin = (state_q == S_PICK) && sv_q && (CW'(sidx_q) == (n_q - CW'(1)));
  assign fin_idx  = cand ? sidx_q : sbest_idx_q;
  assign better   = !bfound_q || (ch_span < bspan_q);
  assign wr_a     = pick_fin && (k_q == '0);
  assign wr_b     = (state_q == S_BUILD) && g1_tok_q.valid;
  assign we0      = (wr_a && !cur_q) || (wr_b && cur_q);
  assign we1      = (wr_a && cur_q) || (wr_b && !cur_q);
  assign wa       = wr_a ? '0 : g1_t_q[JW-1:0];
  assign wd       = wr_a ? fin_idx : g1_job;
  assign sum_we   = (state_q == S_SUMS) && ch_done;
  assign span_sat = (32'(ch_span) > 32'(nfs_pkg::SpanMax)) ? nfs_pkg::SpanMax
                                                          : nfs_pkg::MakespanW'(ch_span);

  always_ff @(posedge clk_i) begin
    if (we0) begin
      seq0[wa] <= wd;
    end
    if (we1) begin
      seq1[wa] <= wd;
    end
    if (sum_we) begin
      sums[rc_q[JW-1:0]] <= ch_span;
    end
    seq0_rd_q <= seq0[seq_rd_addr];
    seq1_rd_q <= seq1[seq_rd_addr];
    sums_rd_q <= sums[ra_q[JW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      job_count_q     <= 7'd1;
      machine_count_q <= 6'd1;
      n_q <= '0; iss_q <= '0; rc_q <= '0; ra_q <= '0; k_q <= '0;
      len_q <= '0; pos_q <= '0; bpos_q <= '0; g_t_q <= '0; g_len_q <= '0;
      g1_t_q <= '0; o_cnt_q <= '0; m_q <= '0; chosen_q <= '0;
      s_run_q <= 1'b0; sv_q <= 1'b0; sfound_q <= 1'b0; bfound_q <= 1'b0;
      cur_q <= 1'b0; g_run_q <= 1'b0; g1_new_q <= 1'b0;
      sidx_q <= '0; sbest_idx_q <= '0; newjob_q <= '0;
      sbest_q <= '0; bspan_q <= '0; g1_tok_q <= '0; span_q <= '0;
      m_pos_q <= '0; m_job_q <= '0; m_valid_q <= 1'b0; m_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nfs_pkg::REG_JOB_COUNT:     job_count_q     <= cfg_data_i;
          nfs_pkg::REG_MACHINE_COUNT: machine_count_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end

      // generator advance and stage 1
      g1_tok_q.valid <= g_run_q;
      g1_tok_q.first <= (g_t_q == '0);
      g1_tok_q.tail  <= (g_t_q == (g_len_q - CW'(1)));
      g1_new_q       <= g_new;
      g1_t_q         <= g_t_q;
      if (g_run_q) begin
        if (g_t_q == (g_len_q - CW'(1))) begin
          g_run_q <= 1'b0;
        end else begin
          g_t_q <= g_t_q + CW'(1);
        end
      end

      // priority sweep
      sv_q   <= s_run_q;
      sidx_q <= ra_q[JW-1:0];
      if (s_run_q) begin
        if (ra_q == (n_q - CW'(1))) begin
          s_run_q <= 1'b0;
        end else begin
          ra_q <= ra_q + CW'(1);
        end
      end
      if (sv_q && cand) begin
        sfound_q    <= 1'b1;
        sbest_q     <= sums_rd_q;
        sbest_idx_q <= sidx_q;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tlast) begin
            n_q     <= n_sat;
            m_q     <= m_sat;
            iss_q   <= '0;
            rc_q    <= '0;
            state_q <= S_SUMS;
          end
        end
        S_SUMS: begin
          if (iss_q < n_q) begin
            iss_q <= iss_q + CW'(1);
          end
          if (ch_done) begin
            rc_q <= rc_q + CW'(1);
            if (rc_q == (n_q - CW'(1))) begin
              chosen_q <= '0;
              k_q      <= '0;
              s_run_q  <= 1'b1;
              ra_q     <= '0;
              sfound_q <= 1'b0;
              state_q  <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (pick_fin) begin
            chosen_q[fin_idx] <= 1'b1;
            newjob_q          <= fin_idx;
            if (k_q == '0) begin
              len_q <= CW'(1);
              k_q   <= CW'(1);
              if (n_q == CW'(1)) begin
                pos_q   <= CW'(1);
                g_run_q <= 1'b1;
                g_t_q   <= '0;
                g_len_q <= CW'(1);
                state_q <= S_FINAL;
              end else begin
                s_run_q  <= 1'b1;
                ra_q     <= '0;
                sfound_q <= 1'b0;
              end
            end else begin
              pos_q    <= '0;
              bfound_q <= 1'b0;
              g_run_q  <= 1'b1;
              g_t_q    <= '0;
              g_len_q  <= len_q + CW'(1);
              state_q  <= S_TRIAL;
            end
          end
        end
        S_TRIAL: begin
          if (ch_done) begin
            if (better) begin
              bfound_q <= 1'b1;
              bspan_q  <= ch_span;
              bpos_q   <= pos_q;
            end
            g_run_q <= 1'b1;
            g_t_q   <= '0;
            g_len_q <= len_q + CW'(1);
            if (pos_q == len_q) begin
              pos_q   <= better ? pos_q : bpos_q;
              state_q <= S_BUILD;
            end else begin
              pos_q <= pos_q + CW'(1);
            end
          end
        end
        S_BUILD: begin
          if (g1_tok_q.valid && g1_tok_q.tail) begin
            cur_q <= !cur_q;
            len_q <= len_q + CW'(1);
            k_q   <= k_q + CW'(1);
            if ((k_q + CW'(1)) == n_q) begin
              pos_q   <= len_q + CW'(1);
              g_run_q <= 1'b1;
              g_t_q   <= '0;
              g_len_q <= len_q + CW'(1);
              state_q <= S_FINAL;
            end else begin
              s_run_q  <= 1'b1;
              ra_q     <= '0;
              sfound_q <= 1'b0;
              state_q  <= S_PICK;
            end
          end
        end
        S_FINAL: begin
          if (ch_done) begin
            span_q  <= span_sat;
            o_cnt_q <= '0;
            state_q <= S_ORD;
          end
        end
        S_ORD: begin
          state_q <= S_OWT;
        end
        S_OWT: begin
          m_pos_q   <= 6'(o_cnt_q);
          m_job_q   <= 6'(seq_rd);
          m_last_q  <= (o_cnt_q == (n_q - CW'(1)));
          m_valid_q <= 1'b1;
          state_q   <= S_OHOLD;
        end
        S_OHOLD: begin
          if (m_axis_tready) begin
            m_valid_q <= 1'b0;
            if (m_last_q) begin
              state_q <= S_IDLE;
            end else begin
              o_cnt_q <= o_cnt_q + CW'(1);
              state_q <= S_ORD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, span_q, m_job_q, m_pos_q};
  assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire
